// ===== rtl/ows_pkg.sv =====
package ows_pkg;

    // rom id geometry
    localparam int unsigned RomBits = 64;
    localparam int unsigned PosW    = 7;
    localparam int unsigned IdxW    = 6;
    localparam int unsigned CrcW    = 8;

    // dallas crc-8, reflected polynomial x^8+x^5+x^4+1
    localparam logic [CrcW-1:0] CrcPolyRef = 8'h8C;

    // request operation codes
    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_BIT   = 2'd2
    } t_op;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FOUND   = 3'd1,
        ST_CRC_ERR = 3'd2,
        ST_ABORT   = 3'd3,
        ST_NO_PRES = 3'd4,
        ST_IGNORED = 3'd5
    } t_status;

    // search state kept between requests
    typedef struct packed {
        logic [RomBits-1:0] rom_bits;
        logic [PosW-1:0]    last_conflict_pos;
        logic [PosW-1:0]    last_zero_pos;
        logic [PosW-1:0]    bit_position;
        logic               last_found;
        logic [CrcW-1:0]    crc_acc;
        logic               in_pass;
    } t_state;

    // one result
    typedef struct packed {
        logic               drive_bit;
        t_status            status;
        logic               pass_done;
        logic               last_device;
        logic [RomBits-1:0] rom_id;
    } t_result;

    // one request
    typedef struct packed {
        logic [1:0] operation;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } t_req;

    // one bit of the crc shift register
    function automatic logic [CrcW-1:0] crc_bit(input logic [CrcW-1:0] crc, input logic b);
        logic [CrcW-1:0] sh;
        sh = crc >> 1;
        if (crc[0] ^ b) begin
            sh = sh ^ CrcPolyRef;
        end
        return sh;
    endfunction

endpackage

// ===== rtl/onewire_rom_search_top.sv =====
// 1-Wire ROM search engine. Takes one request per cycle while o_in_stall is low (init,
// begin pass, or one read bit pair) and returns exactly one result per request: the
// direction bit to write back, a status, pass-done and last-device flags and the ROM
// ID. A request sits in an input register, where the search step is evaluated
// against the stored search state; the result lands in an output register, and the
// sustained rate is one request per cycle while i_out_stall is low. The search state
// is updated in the same cycle the result is registered, so each request sees the
// effect of the one before it. Holding i_out_stall stops the output register and,
// one request later, the input.
module onewire_rom_search_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic        i_presence,
    input  logic        i_id_bit,
    input  logic        i_complement_bit,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_drive_bit,
    output logic [2:0]  o_status,
    output logic        o_pass_done,
    output logic        o_last_device,
    output logic [63:0] o_rom_id
);
    import ows_pkg::*;

    logic    r_in_valid;
    t_req    r_req;
    logic    r_out_valid;
    t_result r_res;
    t_state  r_st;
    t_state  n_st;
    t_result n_res;
    logic    out_free;
    logic    advance;
    logic    in_take;

    // pipeline advance
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // search step
    ows_step u_step (
        .i_state  (r_st),
        .i_req    (r_req),
        .o_state  (n_st),
        .o_result (n_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req.operation      <= i_operation;
            r_req.presence       <= i_presence;
            r_req.id_bit         <= i_id_bit;
            r_req.complement_bit <= i_complement_bit;
        end
    end

    // search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.rom_bits          <= '0;
            r_st.last_conflict_pos <= '0;
            r_st.last_zero_pos     <= '0;
            r_st.bit_position      <= PosW'(1);
            r_st.last_found        <= 1'b0;
            r_st.crc_acc           <= '0;
            r_st.in_pass           <= 1'b0;
        end else if (advance) begin
            r_st <= n_st;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_bit   = r_res.drive_bit;
    assign o_status      = r_res.status;
    assign o_pass_done   = r_res.pass_done;
    assign o_last_device = r_res.last_device;
    assign o_rom_id      = r_res.rom_id;

`ifndef ASSERT_OFF
    // a finished pass leaves no pass open
    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_res.pass_done |=> !r_st.in_pass)
        else $error("pass still open after pass_done");

    // an open pass always points at a bit 1..64
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.in_pass |-> (r_st.bit_position != '0) && (r_st.bit_position <= PosW'(RomBits)))
        else $error("bit position out of range inside a pass");

    // pass_done only with a terminal status
    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pass_done |->
            (o_status == ST_FOUND) || (o_status == ST_CRC_ERR) ||
            (o_status == ST_ABORT) || (o_status == ST_NO_PRES))
        else $error("pass_done with a non-terminal status");

    // a driven one only comes from a processed bit pair
    a_drive_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_bit |->
            (o_status == ST_OK) || (o_status == ST_FOUND) || (o_status == ST_CRC_ERR))
        else $error("drive bit set on a request that drove nothing");

    // state only moves when a request is committed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_st))
        else $error("search state changed without a request");
`endif

endmodule

// ===== rtl/ows_step.sv =====
module ows_step (
    input  ows_pkg::t_state  i_state,
    input  ows_pkg::t_req    i_req,
    output ows_pkg::t_state  o_state,
    output ows_pkg::t_result o_result
);
    import ows_pkg::*;

    // one search step: next state and the result of one request
    always_comb begin
        t_state          n_st;
        logic            drive;
        t_status         status;
        logic            done;
        logic [PosW-1:0] pos;
        logic [IdxW-1:0] idx;
        logic [CrcW-1:0] crc_next;

        n_st     = i_state;
        drive    = 1'b0;
        status   = ST_OK;
        done     = 1'b0;
        pos      = i_state.bit_position;
        idx      = pos[IdxW-1:0] - IdxW'(1);
        crc_next = crc_bit(i_state.crc_acc, 1'b0);

        case (i_req.operation)
            OP_INIT: begin
                n_st.last_conflict_pos = '0;
                n_st.last_found        = 1'b0;
                n_st.in_pass           = 1'b0;
            end
            OP_BEGIN: begin
                if (i_req.presence) begin
                    n_st.in_pass       = 1'b1;
                    n_st.bit_position  = PosW'(1);
                    n_st.last_zero_pos = '0;
                    n_st.crc_acc       = '0;
                end else begin
                    n_st.in_pass = 1'b0;
                    status       = ST_NO_PRES;
                    done         = 1'b1;
                end
            end
            OP_BIT: begin
                if (!i_state.in_pass) begin
                    status = ST_IGNORED;
                end else if (i_req.id_bit && i_req.complement_bit) begin
                    // nobody answered: abort the search
                    n_st.last_found = 1'b1;
                    n_st.in_pass    = 1'b0;
                    status          = ST_ABORT;
                    done            = 1'b1;
                end else begin
                    // pick the direction
                    if (i_req.id_bit) begin
                        drive = 1'b1;
                    end else if (i_req.complement_bit) begin
                        drive = 1'b0;
                    end else if (pos == i_state.last_conflict_pos) begin
                        drive = 1'b1;
                    end else if (pos > i_state.last_conflict_pos) begin
                        drive              = 1'b0;
                        n_st.last_zero_pos = pos;
                    end else begin
                        drive = i_state.rom_bits[idx];
                        if (!drive) begin
                            n_st.last_zero_pos = pos;
                        end
                    end
                    n_st.rom_bits[idx] = drive;
                    crc_next           = crc_bit(i_state.crc_acc, drive);
                    n_st.crc_acc       = crc_next;
                    // end of the 64-bit pass
                    if (pos[PosW-1]) begin
                        n_st.last_conflict_pos = n_st.last_zero_pos;
                        if (n_st.last_zero_pos == '0) begin
                            n_st.last_found = 1'b1;
                        end
                        status       = (crc_next == '0) ? ST_FOUND : ST_CRC_ERR;
                        done         = 1'b1;
                        n_st.in_pass = 1'b0;
                    end
                    n_st.bit_position = pos + PosW'(1);
                end
            end
            default: begin
                status = ST_IGNORED;
            end
        endcase

        o_state              = n_st;
        o_result.drive_bit   = drive;
        o_result.status      = status;
        o_result.pass_done   = done;
        o_result.last_device = n_st.last_found;
        o_result.rom_id      = n_st.rom_bits;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ows_pkg::*;

    localparam logic [1:0] OpUnused   = 2'd3;
    localparam int         CycleLimit = 400000;
    localparam int         MaxDevices = 4;

    // clock, reset and dut ports
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_operation      = OP_INIT;
    logic        i_presence       = 1'b0;
    logic        i_id_bit         = 1'b0;
    logic        i_complement_bit = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_drive_bit;
    logic [2:0]  o_status;
    logic        o_pass_done;
    logic        o_last_device;
    logic [63:0] o_rom_id;

    // receiver stall sources
    logic        sink_stall = 1'b0;
    logic        long_hold  = 1'b0;
    int          sink_left  = 0;
    int          hold_cycles_req = 0;
    bit          sink_idle  = 1'b1;
    bit          src_idle   = 1'b1;

    // search state as the block should hold it
    logic [RomBits-1:0] srch_rom      = '0;
    logic [PosW-1:0]    srch_conflict = '0;
    logic [PosW-1:0]    srch_zero     = '0;
    logic [PosW-1:0]    srch_pos      = 7'd1;
    logic               srch_last     = 1'b0;
    logic [CrcW-1:0]    srch_crc      = '0;
    logic               srch_open     = 1'b0;

    // answers still owed by the block, oldest first
    t_result     due_results[$];
    t_result     last_answer;

    // simulated devices on the bus
    logic [63:0] dev_ids[MaxDevices];
    int          dev_count   = 0;

    int          req_count   = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    assign i_out_stall = sink_stall | long_hold;

    onewire_rom_search_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_presence       (i_presence),
        .i_id_bit         (i_id_bit),
        .i_complement_bit (i_complement_bit),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_drive_bit      (o_drive_bit),
        .o_status         (o_status),
        .o_pass_done      (o_pass_done),
        .o_last_device    (o_last_device),
        .o_rom_id         (o_rom_id)
    );

    always #10 i_clk = ~i_clk;

    // dallas crc-8, one bit, lsb first
    function automatic logic [CrcW-1:0] crc8_step(input logic [CrcW-1:0] crc, input logic b);
        logic fb;
        fb  = crc[0] ^ b;
        crc = {1'b0, crc[CrcW-1:1]};
        if (fb) begin
            crc = crc ^ CrcPolyRef;
        end
        return crc;
    endfunction

    // one search step: updates the shadow state, returns the expected answer
    function automatic t_result search_step(input logic [1:0] op, input logic pres,
                                            input logic idb, input logic cmp);
        t_result         r;
        logic [PosW-1:0] pos;
        logic [IdxW-1:0] idx;
        logic            drv;
        r        = '0;
        r.status = ST_OK;
        drv      = 1'b0;
        if (op == OP_INIT) begin
            srch_conflict = '0;
            srch_last     = 1'b0;
            srch_open     = 1'b0;
        end else if (op == OP_BEGIN) begin
            if (pres) begin
                srch_open = 1'b1;
                srch_pos  = 7'd1;
                srch_zero = '0;
                srch_crc  = '0;
            end else begin
                srch_open   = 1'b0;
                r.status    = ST_NO_PRES;
                r.pass_done = 1'b1;
            end
        end else if (op == OP_BIT && srch_open) begin
            pos = srch_pos;
            idx = IdxW'(pos - 7'd1);
            if (idb && cmp) begin
                // nobody answered: search over
                srch_last   = 1'b1;
                srch_open   = 1'b0;
                r.status    = ST_ABORT;
                r.pass_done = 1'b1;
            end else begin
                // pick the branch to follow
                if (idb) begin
                    drv = 1'b1;
                end else if (cmp) begin
                    drv = 1'b0;
                end else if (pos == srch_conflict) begin
                    drv = 1'b1;
                end else if (pos > srch_conflict) begin
                    drv       = 1'b0;
                    srch_zero = pos;
                end else begin
                    drv = srch_rom[idx];
                    if (!drv) begin
                        srch_zero = pos;
                    end
                end
                srch_rom[idx] = drv;
                srch_crc      = crc8_step(srch_crc, drv);
                // last bit closes the pass
                if (pos >= RomBits) begin
                    srch_conflict = srch_zero;
                    if (srch_conflict == '0) begin
                        srch_last = 1'b1;
                    end
                    r.status    = (srch_crc == '0) ? ST_FOUND : ST_CRC_ERR;
                    r.pass_done = 1'b1;
                    srch_open   = 1'b0;
                end
                srch_pos    = pos + 7'd1;
                r.drive_bit = drv;
            end
        end else begin
            r.status = ST_IGNORED;
        end
        r.last_device = srch_last;
        r.rom_id      = srch_rom;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    endtask

    // offer one request, wait for it to be taken, then predict its answer
    task automatic send_req(input logic [1:0] op, input logic pres, input logic idb,
                            input logic cmp);
        int gap;
        gap = src_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_presence       <= pres;
        i_id_bit         <= idb;
        i_complement_bit <= cmp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        last_answer = search_step(op, pres, idb, cmp);
        due_results.push_back(last_answer);
        req_count++;
    endtask

    // stop offering and wait until every answer is in
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // one pass over the simulated bus, wired-and of the devices still in play
    task automatic run_pass(input int corrupt_at, input int cut_at);
        logic [MaxDevices-1:0] alive;
        logic                  id_and;
        logic                  cmp_and;
        int                    b;
        int                    k;
        for (k = 0; k < MaxDevices; k++) begin
            alive[k] = (k < dev_count);
        end
        send_req(OP_BEGIN, 1'b1, 1'($urandom), 1'($urandom));
        for (b = 0; b < 64 && b != cut_at; b++) begin
            id_and  = 1'b1;
            cmp_and = 1'b1;
            for (k = 0; k < MaxDevices; k++) begin
                if (alive[k]) begin
                    id_and  = id_and & dev_ids[k][b];
                    cmp_and = cmp_and & ~dev_ids[k][b];
                end
            end
            if (b == corrupt_at) begin
                {id_and, cmp_and} = 2'($urandom);
            end
            send_req(OP_BIT, 1'($urandom), id_and, cmp_and);
            if (last_answer.pass_done) begin
                break;
            end
            // devices that lost this bit drop out
            for (k = 0; k < MaxDevices; k++) begin
                if (dev_ids[k][b] != last_answer.drive_bit) begin
                    alive[k] = 1'b0;
                end
            end
        end
    endtask

    // init, bit pairs outside a pass, unused operation
    task automatic test_idle_requests();
        send_req(OP_INIT, 1'b1, 1'b1, 1'b1);
        send_req(OP_BIT, 1'b0, 1'b0, 1'b0);
        send_req(OP_BIT, 1'b1, 1'b1, 1'b1);
        send_req(OpUnused, 1'b1, 1'b1, 1'b1);
        send_req(OpUnused, 1'b0, 1'b0, 1'b0);
    endtask

    // begin without presence leaves no pass open
    task automatic test_no_presence();
        send_req(OP_BEGIN, 1'b0, 1'b1, 1'b0);
        send_req(OP_BIT, 1'b0, 1'b0, 1'b1);
    endtask

    // both read slots high aborts the pass
    task automatic test_abort();
        send_req(OP_INIT, 1'b0, 1'b0, 1'b0);
        send_req(OP_BEGIN, 1'b1, 1'b0, 1'b0);
        send_req(OP_BIT, 1'b0, 1'b1, 1'b0);
        send_req(OP_BIT, 1'b1, 1'b0, 1'b1);
        send_req(OP_BIT, 1'b0, 1'b0, 1'b0);
        send_req(OP_BIT, 1'b1, 1'b0, 1'b0);
        send_req(OP_BIT, 1'b0, 1'b1, 1'b1);
        send_req(OP_BIT, 1'b0, 1'b0, 1'b1);
    endtask

    // begin in the middle of a pass restarts it, init closes it
    task automatic test_restart();
        send_req(OP_BEGIN, 1'b1, 1'b1, 1'b1);
        send_req(OP_BIT, 1'b0, 1'b1, 1'b0);
        send_req(OP_BIT, 1'b0, 1'b0, 1'b0);
        send_req(OP_BEGIN, 1'b1, 1'b0, 1'b0);
        send_req(OP_BIT, 1'b1, 1'b0, 1'b0);
        send_req(OP_INIT, 1'b1, 1'b0, 1'b0);
        send_req(OP_BIT, 1'b0, 1'b1, 1'b0);
    endtask

    // full searches over random device populations
    task automatic test_search_population(input int until_count);
        logic [63:0]     base;
        logic [63:0]     rom;
        logic [CrcW-1:0] crc;
        int              ndev;
        int              passes;
        int              split;
        int              k;
        int              b;
        while (req_count < until_count) begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            ndev      = $urandom_range(1, MaxDevices);
            base      = {$urandom, $urandom};
            // shared prefixes push conflicts deep into the id
            for (k = 0; k < ndev; k++) begin
                split = $urandom_range(0, 55);
                rom   = base ^ ({$urandom, $urandom} << split);
                crc   = '0;
                for (b = 0; b < 56; b++) begin
                    crc = crc8_step(crc, rom[b]);
                end
                if ($urandom_range(0, 4) != 0) begin
                    rom[63:56] = crc;
                end
                dev_ids[k] = rom;
            end
            dev_count = ndev;
            send_req(OP_INIT, 1'($urandom), 1'($urandom), 1'($urandom));
            passes = 0;
            do begin
                run_pass(($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : -1,
                         ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : -1);
                passes++;
            end while (!last_answer.last_device && passes < ndev + 2);
            // sometimes repeat a pass after the search loop ends
            if ($urandom_range(0, 2) == 0) begin
                run_pass(-1, -1);
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // receiver holds off while a full pass is offered back to back
    task automatic test_backpressure();
        src_idle = 1'b0;
        send_req(OP_INIT, 1'b0, 1'b0, 1'b0);
        hold_cycles_req = 150;
        run_pass(-1, -1);
        wait_drained();
        src_idle = 1'b1;
    endtask

    // random requests of every kind
    task automatic test_noise(input int count);
        logic [1:0] op;
        int         i;
        for (i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0:       op = OP_INIT;
                1, 2:    op = OP_BEGIN;
                3:       op = OpUnused;
                default: op = OP_BIT;
            endcase
            send_req(op, $urandom_range(0, 3) != 0, 1'($urandom), 1'($urandom));
        end
    endtask

    // receiver: per-result random stall
    always @(posedge i_clk) begin : sink_ctl
        int n;
        if (sink_left > 1) begin
            sink_left <= sink_left - 1;
        end else if (sink_left == 1) begin
            sink_left  <= 0;
            sink_stall <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            n = sink_idle ? $urandom_range(0, 10) : 0;
            sink_left  <= n;
            sink_stall <= (n != 0);
        end
    end

    // long receiver hold-off, counted here
    initial begin : long_hold_ctl
        forever begin
            wait (hold_cycles_req > 0);
            @(posedge i_clk);
            long_hold <= 1'b1;
            repeat (hold_cycles_req) @(posedge i_clk);
            long_hold <= 1'b0;
            hold_cycles_req = 0;
        end
    end

    // compare each taken result with the oldest expected answer
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result", o_rom_id, '0);
            end else begin
                want = due_results.pop_front();
                if (o_drive_bit !== want.drive_bit) begin
                    report_mismatch("drive_bit", 64'(o_drive_bit), 64'(want.drive_bit));
                end
                if (o_status !== want.status) begin
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                end
                if (o_pass_done !== want.pass_done) begin
                    report_mismatch("pass_done", 64'(o_pass_done), 64'(want.pass_done));
                end
                if (o_last_device !== want.last_device) begin
                    report_mismatch("last_device", 64'(o_last_device),
                                    64'(want.last_device));
                end
                if (o_rom_id !== want.rom_id) begin
                    report_mismatch("rom_id", o_rom_id, want.rom_id);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_requests();
        test_no_presence();
        test_abort();
        test_restart();
        test_search_population(650);
        test_backpressure();
        test_search_population(830);
        test_noise(230);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && due_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
